FILE: src/iut_pkg.sv
// ----------------------------------------------------------------------------
// Interval union tracker package
// Shared types and default constants for the interval union tracker.
// ----------------------------------------------------------------------------
package iut_pkg;

   localparam int TableDepth = 256;
   localparam int CoordWidth = 32;

   typedef struct packed {
      logic [31:0] interval_low;
      logic [31:0] interval_high;
      logic        end_of_batch;
   } req_type;

   typedef struct packed {
      logic [8:0]  segment_count;
      logic [31:0] merged_low;
      logic [31:0] merged_high;
      logic        table_full;
      logic        batch_end;
   } rsp_type;

endpackage

FILE: src/interval_union_tracker_top.sv
// ----------------------------------------------------------------------------
// Interval union tracker
// Sorted table of disjoint closed intervals with insert-and-merge.
// ----------------------------------------------------------------------------
// One memory read port walks the table twice: a merge pass, then a compaction
// pass that writes the surviving entries and the merged entry into the other
// bank. A full table that absorbs nothing skips the compaction pass.
// Throughput: one item at a time; no new item is taken until the result is taken.
// Reset clears the entry count and control state; table contents are not
// cleared, since entries beyond the count are never used.
module interval_union_tracker_top #(
   parameter int TABLE_DEPTH = iut_pkg::TableDepth,
   parameter int COORD_WIDTH = iut_pkg::CoordWidth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iut_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iut_pkg::rsp_type  rsp_data
);

   localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

   typedef enum logic [2:0] {
      S_IDLE, S_P1, S_DECIDE, S_P2, S_TAIL, S_OUT
   } state_type;

   typedef logic [COORD_WIDTH-1:0] coord_type;

   // Two banks; pass two reads one and writes the other, then they swap.
   coord_type mem_lo [2][TABLE_DEPTH];
   coord_type mem_hi [2][TABLE_DEPTH];

   state_type        state_ff;
   logic             bank_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    rd_ff;
   logic [CW-1:0]    wr_ff;
   logic             rvalid_ff;
   coord_type        rlo_ff, rhi_ff;
   coord_type        lo_ff, hi_ff, mlo_ff, mhi_ff;
   logic             absorbed_ff;
   logic             placed_ff;
   logic             full_ff;
   logic             eob_ff;
   logic             pend_ff;
   coord_type        plo_ff, phi_ff;

   coord_type        in_lo, in_hi, ovl_max, ovl_min;
   logic             ovl;
   logic             hold_rd;
   logic             pend_in;

   always_comb begin
      in_lo = coord_type'(req_data.interval_low);
      in_hi = coord_type'(req_data.interval_high);
      ovl_max = (lo_ff > rlo_ff) ? lo_ff : rlo_ff;
      ovl_min = (hi_ff < rhi_ff) ? hi_ff : rhi_ff;
      ovl = ovl_max <= ovl_min;
      // The merged entry is written ahead of the survivor now on the read port.
      hold_rd = (state_ff == S_P2) && rvalid_ff && !ovl && !placed_ff && (rlo_ff > mlo_ff);
      pend_in = ((state_ff == S_P2) && rvalid_ff && !ovl)
             || ((state_ff == S_TAIL) && !pend_ff && !placed_ff);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      rsp_data.segment_count = 9'(count_ff);
      rsp_data.merged_low    = 32'(mlo_ff[IW-1:0]);
      rsp_data.merged_high   = 32'(mhi_ff[IW-1:0]);
      rsp_data.table_full    = full_ff;
      rsp_data.batch_end     = eob_ff;
   end

   // Read port: registered data, one entry a cycle; the data is kept while the
   // merged entry takes a write slot.
   always_ff @(posedge clock) begin
      if (!hold_rd) begin
         rlo_ff <= mem_lo[bank_ff][rd_ff[AW-1:0]];
         rhi_ff <= mem_hi[bank_ff][rd_ff[AW-1:0]];
      end
   end

   // Write port into the other bank.
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         mem_lo[~bank_ff][wr_ff[AW-1:0]] <= plo_ff;
         mem_hi[~bank_ff][wr_ff[AW-1:0]] <= phi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         bank_ff   <= 1'b0;
         count_ff  <= '0;
         rd_ff     <= '0;
         wr_ff     <= '0;
         rvalid_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (pend_ff) begin
            wr_ff <= wr_ff + 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (in_lo > in_hi) begin
                     lo_ff <= in_hi; hi_ff <= in_lo; mlo_ff <= in_hi; mhi_ff <= in_lo;
                  end else begin
                     lo_ff <= in_lo; hi_ff <= in_hi; mlo_ff <= in_lo; mhi_ff <= in_hi;
                  end
                  eob_ff      <= req_data.end_of_batch;
                  absorbed_ff <= 1'b0;
                  full_ff     <= 1'b0;
                  rd_ff       <= '0;
                  rvalid_ff   <= 1'b0;
                  state_ff    <= S_P1;
               end
            end
            S_P1: begin
               // Read issued at rd_ff; data arrives in the next cycle.
               if (rvalid_ff && ovl) begin
                  absorbed_ff <= 1'b1;
                  if (rlo_ff < mlo_ff) mlo_ff <= rlo_ff;
                  if (rhi_ff > mhi_ff) mhi_ff <= rhi_ff;
               end
               if (rd_ff < count_ff) begin
                  rd_ff     <= rd_ff + 1'b1;
                  rvalid_ff <= 1'b1;
               end else begin
                  rvalid_ff <= 1'b0;
                  state_ff  <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               // No write is pending here, so the write index is free to clear.
               rd_ff     <= '0;
               wr_ff     <= '0;
               placed_ff <= 1'b0;
               rvalid_ff <= 1'b0;
               if (!absorbed_ff && count_ff >= CW'(TABLE_DEPTH)) begin
                  full_ff  <= 1'b1;
                  mlo_ff   <= lo_ff;
                  mhi_ff   <= hi_ff;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_P2;
               end
            end
            S_P2: begin
               // The merged entry goes in before the first survivor above it;
               // that takes two write slots, so the walk pauses with
               // the survivor held on the read port.
               if (hold_rd) begin
                  placed_ff <= 1'b1;
                  plo_ff    <= mlo_ff;
                  phi_ff    <= mhi_ff;
                  rvalid_ff <= 1'b1;
               end else begin
                  if (rvalid_ff && !ovl) begin
                     plo_ff  <= rlo_ff;
                     phi_ff  <= rhi_ff;
                  end
                  if (rd_ff < count_ff) begin
                     rd_ff     <= rd_ff + 1'b1;
                     rvalid_ff <= 1'b1;
                  end else begin
                     rvalid_ff <= 1'b0;
                     state_ff  <= S_TAIL;
                  end
               end
            end
            S_TAIL: begin
               if (!pend_ff) begin
                  if (!placed_ff) begin
                     placed_ff <= 1'b1;
                     plo_ff    <= mlo_ff;
                     phi_ff    <= mhi_ff;
                  end else begin
                     count_ff <= wr_ff;
                     bank_ff  <= ~bank_ff;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
